// File: src/kcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_pkg: shared definitions for the knob to MIDI CC block
// Field widths, register codes, request codes, controller states, constants.
// ----------------------------------------------------------------------------
package kcc_pkg;

   localparam int NUM_KNOBS_DEF   = 8;
   localparam int SAMPLE_BITS_DEF = 12;

   localparam int REQ_TYPE_W   = 2;
   localparam int KNOB_INDEX_W = 3;
   localparam int KNOB_VALUE_W = 12;

   localparam int STATUS_W  = 8;
   localparam int CC_W      = 7;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int CHANNEL_W   = 4;
   localparam int BANK_W      = 4;
   localparam int THRESHOLD_W = 12;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 12'd409;
   localparam logic [STATUS_W-1:0]    STATUS_CC       = 8'hB0;
   localparam logic [CC_W-1:0]        CC_BASE         = 7'd10;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_SELECT = 2'd1,
      REQ_SEND   = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIDI_CHANNEL   = 2'd0,
      CSR_BANK_INDEX     = 2'd1,
      CSR_MOVE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_SEND
   } ctrl_state_type;

endpackage

// File: src/kcc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_ifs: channel interfaces
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface kcc_req_if;
   import kcc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [REQ_TYPE_W-1:0]   req_type;
   logic [KNOB_INDEX_W-1:0] knob_index;
   logic [KNOB_VALUE_W-1:0] knob_value;

   modport source (output valid, output req_type, output knob_index, output knob_value,
                   input ready);
   modport sink   (input valid, input req_type, input knob_index, input knob_value,
                   output ready);
endinterface

interface kcc_rsp_if;
   import kcc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status_byte;
   logic [CC_W-1:0]         controller_number;
   logic [CC_W-1:0]         controller_value;
   logic [KNOB_INDEX_W-1:0] source_knob;
   logic                    last;

   modport source (output valid, output status_byte, output controller_number,
                   output controller_value, output source_knob, output last,
                   input ready);
   modport sink   (input valid, input status_byte, input controller_number,
                   input controller_value, input source_knob, input last,
                   output ready);
endinterface

interface kcc_csr_if;
   import kcc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/kcc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_store: per-knob state memory
// One write port, one registered read port; entries never written read zero.
// ----------------------------------------------------------------------------
module kcc_store #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 20,
   parameter int AW    = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_q_ff;
   logic             rd_hit_ff;
   logic             rd_hit_in;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // valid bit per entry stands in for the all-zero reset of the array
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_hit_in = rd_en ? valid_ff[rd_addr] : rd_hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rd_hit_ff <= rd_hit_in;
      end
   end

   assign rd_data = rd_hit_ff ? rd_q_ff : '0;

endmodule

// File: src/kcc_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_update: knob entry modify logic
// Move test against the threshold, pickup release and 7-bit CC scaling.
// ----------------------------------------------------------------------------
module kcc_update #(
   parameter int SAMPLE_BITS = 12,
   parameter int VW          = 12
) (
   input  logic                            is_select,
   input  logic [VW-1:0]                   sample,
   input  logic [kcc_pkg::THRESHOLD_W-1:0] threshold,
   input  logic [VW-1:0]                   old_last,
   input  logic                            old_wait,
   input  logic [kcc_pkg::CC_W-1:0]        old_cc,
   output logic [VW-1:0]                   new_last,
   output logic                            new_wait,
   output logic [kcc_pkg::CC_W-1:0]        new_cc,
   output logic                            accept
);
   import kcc_pkg::*;

   localparam int TW = SAMPLE_BITS + CC_W + 1;

   logic [VW-1:0] diff;
   logic          moved;
   logic [TW-1:0] prod;
   logic [TW-1:0] sum;
   logic [CC_W-1:0] scaled;

   assign diff  = (sample > old_last) ? (sample - old_last) : (old_last - sample);
   assign moved = KNOB_VALUE_W'(diff) > threshold;

   // floor(s*127 / (2^n-1)): x/(2^n-1) == (x + (x>>n) + 1) >> n for x < 2^(2n)-1
   assign prod   = (TW'(sample) << CC_W) - TW'(sample);
   assign sum    = prod + (prod >> SAMPLE_BITS) + TW'(1);
   assign scaled = CC_W'(sum >> SAMPLE_BITS);

   always_comb begin
      new_last = old_last;
      new_wait = old_wait;
      new_cc   = old_cc;
      accept   = 1'b0;
      if (is_select) begin
         new_last = sample;
         new_wait = 1'b1;
      end else if (moved) begin
         // a move past the threshold both releases pickup and is taken
         new_wait = 1'b0;
         new_last = sample;
         new_cc   = scaled;
         accept   = 1'b1;
      end
   end

endmodule

// File: src/knob_to_midi_cc_with_pickup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_to_midi_cc_with_pickup: knob bank to MIDI control-change converter
// Soft takeover per knob, pending marks, send runs emitting CC messages.
// ----------------------------------------------------------------------------
// Usage:
//  req_bus : one transaction per request: sample (0), select (1) or send (2).
//  rsp_bus : one transaction per CC message; last marks the end of a send run.
//  csr_bus : register writes (channel, bank, threshold), always ready; write
//            only while the block is idle.
// Timing:
//  Sample/select: memory read, then modify and write back; no response.
//  Send: the first message passes through the memory read register, then
//  the output register; after that one message per cycle while
//  rsp_bus.ready is high. The rate is set by the single read port of the
//  knob state memory, read once per knob touched.
//  Requests are taken one at a time; ready is high in the idle state, even
//  while the last message of a run still waits in the output register.
//  A stalled receiver holds the output register and pauses the send run.
// Reset: registers to defaults (threshold 409), all pending marks clear and
//  every knob entry reads as zero until written; no clearing pass needed.
// ----------------------------------------------------------------------------
module knob_to_midi_cc_with_pickup #(
   parameter int NUM_KNOBS   = kcc_pkg::NUM_KNOBS_DEF,
   parameter int SAMPLE_BITS = kcc_pkg::SAMPLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   kcc_req_if.sink    req_bus,
   kcc_rsp_if.source  rsp_bus,
   kcc_csr_if.sink    csr_bus
);
   import kcc_pkg::*;

   localparam int AW = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;
   localparam int VW = (SAMPLE_BITS < KNOB_VALUE_W) ? SAMPLE_BITS : KNOB_VALUE_W;
   localparam int EW = VW + 1 + CC_W;

   // ---------------- configuration registers ----------------
   logic [CHANNEL_W-1:0]   channel_ff,   channel_in;
   logic [BANK_W-1:0]      bank_ff,      bank_in;
   logic [THRESHOLD_W-1:0] threshold_ff, threshold_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      channel_in   = channel_ff;
      bank_in      = bank_ff;
      threshold_in = threshold_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_MIDI_CHANNEL:   channel_in   = csr_bus.data[CHANNEL_W-1:0];
            CSR_BANK_INDEX:     bank_in      = csr_bus.data[BANK_W-1:0];
            CSR_MOVE_THRESHOLD: threshold_in = csr_bus.data[THRESHOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff   <= '0;
         bank_ff      <= '0;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         channel_ff   <= channel_in;
         bank_ff      <= bank_in;
         threshold_ff <= threshold_in;
      end
   end

   // ---------------- control signals ----------------
   ctrl_state_type state_ff, state_in;

   logic                 req_ready;
   logic                 req_fire;
   logic                 knob_ok;
   logic                 is_modify_req;
   logic                 is_send_req;
   logic                 slot_free;
   logic                 emit;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [EW-1:0]        rd_data;
   logic                 wr_en;
   logic [EW-1:0]        wr_data;

   // latched request for the modify cycle
   logic                 cur_select_ff, cur_select_in;
   logic [AW-1:0]        cur_addr_ff,   cur_addr_in;
   logic [VW-1:0]        cur_val_ff,    cur_val_in;

   // pending marks and their scan
   logic [NUM_KNOBS-1:0] pending_ff, pending_in;
   logic [NUM_KNOBS-1:0] low_hot;
   logic [NUM_KNOBS-1:0] remain;
   logic [AW-1:0]        low_idx;
   logic [AW-1:0]        next_idx;

   // entry update
   logic [VW-1:0]        new_last;
   logic                 new_wait;
   logic [CC_W-1:0]      new_cc;
   logic                 upd_accept;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [CC_W-1:0]         rsp_number_ff;
   logic [CC_W-1:0]         rsp_value_ff;
   logic [KNOB_INDEX_W-1:0] rsp_knob_ff;
   logic                    rsp_last_ff;

   assign req_fire      = req_bus.valid && req_ready;
   assign knob_ok       = int'(req_bus.knob_index) < NUM_KNOBS;
   assign is_modify_req = (req_bus.req_type inside {REQ_SAMPLE, REQ_SELECT}) && knob_ok;
   assign is_send_req   = (req_bus.req_type == REQ_SEND) && (pending_ff != '0);
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;

   // lowest pending knob, and the one after it
   assign low_hot = pending_ff & (~pending_ff + NUM_KNOBS'(1));
   assign remain  = pending_ff & ~low_hot;

   always_comb begin
      low_idx  = '0;
      next_idx = '0;
      for (int k = NUM_KNOBS - 1; k >= 0; k--) begin
         if (pending_ff[k]) begin
            low_idx = AW'(k);
         end
         if (remain[k]) begin
            next_idx = AW'(k);
         end
      end
   end

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (is_modify_req) begin
                  state_in = ST_MODIFY;
               end else if (is_send_req) begin
                  state_in = ST_SEND;
               end
            end
         end
         ST_MODIFY: state_in = ST_IDLE;
         ST_SEND: begin
            if (slot_free && (remain == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = low_idx;
      wr_en     = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               if (is_modify_req) begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(req_bus.knob_index);
               end else if (is_send_req) begin
                  rd_en   = 1'b1;
                  rd_addr = low_idx;
               end
            end
         end
         ST_MODIFY: wr_en = 1'b1;
         ST_SEND: begin
            // read data holds the lowest pending knob; prefetch the next one
            if (slot_free) begin
               emit = 1'b1;
               if (remain != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = next_idx;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_bus.ready = req_ready;

   // ---------------- request latch ----------------
   always_comb begin
      cur_select_in = cur_select_ff;
      cur_addr_in   = cur_addr_ff;
      cur_val_in    = cur_val_ff;
      if (req_fire) begin
         cur_select_in = req_bus.req_type == REQ_SELECT;
         cur_addr_in   = AW'(req_bus.knob_index);
         cur_val_in    = req_bus.knob_value[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      cur_select_ff <= cur_select_in;
      cur_addr_ff   <= cur_addr_in;
      cur_val_ff    <= cur_val_in;
   end

   // ---------------- knob state memory ----------------
   kcc_store #(
      .DEPTH (NUM_KNOBS),
      .WIDTH (EW),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (cur_addr_ff),
      .wr_data (wr_data)
   );

   // entry layout: {last_accepted, pickup_wait, cc_level}
   kcc_update #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .VW          (VW)
   ) u_update (
      .is_select (cur_select_ff),
      .sample    (cur_val_ff),
      .threshold (threshold_ff),
      .old_last  (rd_data[EW-1 -: VW]),
      .old_wait  (rd_data[CC_W]),
      .old_cc    (rd_data[CC_W-1:0]),
      .new_last  (new_last),
      .new_wait  (new_wait),
      .new_cc    (new_cc),
      .accept    (upd_accept)
   );

   assign wr_data = {new_last, new_wait, new_cc};

   // ---------------- pending marks ----------------
   always_comb begin
      pending_in = pending_ff;
      if (wr_en && upd_accept) begin
         pending_in[cur_addr_ff] = 1'b1;
      end
      if (emit) begin
         pending_in = remain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= STATUS_CC | STATUS_W'(channel_ff);
         rsp_number_ff <= CC_BASE + {bank_ff, 3'b000} + CC_W'(low_idx);
         rsp_value_ff  <= rd_data[CC_W-1:0];
         rsp_knob_ff   <= KNOB_INDEX_W'(low_idx);
         rsp_last_ff   <= remain == '0;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.status_byte       = rsp_status_ff;
   assign rsp_bus.controller_number = rsp_number_ff;
   assign rsp_bus.controller_value  = rsp_value_ff;
   assign rsp_bus.source_knob       = rsp_knob_ff;
   assign rsp_bus.last              = rsp_last_ff;

`ifndef ASSERT_OFF
   a_send_has_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEND |-> pending_ff != '0)
      else $error("send run with no pending knob");

   a_emit_clears_one: assert property (@(posedge clock) disable iff (reset)
      emit |=> $countones(pending_ff) == $countones($past(pending_ff)) - 1)
      else $error("message did not clear exactly one pending mark");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      emit && (remain == '0) |=> pending_ff == '0 && rsp_bus.valid && rsp_bus.last)
      else $error("final message left pending marks or lost last flag");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("memory read and write in the same cycle");
`endif

endmodule

// File: sim/knob_to_midi_cc_with_pickup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_to_midi_cc_with_pickup_tb: self-checking bench for the knob CC block
// Runs a scripted opening sequence, then random traffic under several register
// settings. Expected CC messages come from a mirror of the knob bank and are
// checked field by field against every response transaction.
// ----------------------------------------------------------------------------
module knob_to_midi_cc_with_pickup_tb;
   import kcc_pkg::*;

   // Request code the block must ignore, and a register index with no register.
   localparam logic [REQ_TYPE_W-1:0]  REQ_UNKNOWN = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE   = 2'd3;

   localparam int FULL_SCALE      = (1 << KNOB_VALUE_W) - 1;
   localparam int ITEMS_PER_PHASE = 55;
   localparam int SETTLE_CYCLES   = 8;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [CC_W-1:0]         number;
      logic [CC_W-1:0]         level;
      logic [KNOB_INDEX_W-1:0] knob;
      logic                    last;
   } cc_msg_type;

   // Opening script. Rows marked fixed carry their expected message (or none)
   // typed in; the others are checked against the knob bank mirror.
   typedef struct packed {
      logic [REQ_TYPE_W-1:0]   kind;
      logic [KNOB_INDEX_W-1:0] knob;
      logic [KNOB_VALUE_W-1:0] value;
      logic                    fixed;
      logic                    has_msg;
      logic [CC_W-1:0]         number;
      logic [CC_W-1:0]         level;
      logic [KNOB_INDEX_W-1:0] src;
   } script_row_type;

   localparam script_row_type SCRIPT [0:20] = '{
      // empty send right after reset, then an unknown request: no messages
      '{REQ_SEND,    3'd0, 12'd0,    1'b1, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_UNKNOWN, 3'd5, 12'd4095, 1'b1, 1'b0, 7'd0,  7'd0,   3'd0},
      // full scale on knob 0 gives level 127 on CC 10
      '{REQ_SAMPLE,  3'd0, 12'd4095, 1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SEND,    3'd0, 12'd0,    1'b1, 1'b1, 7'd10, 7'd127, 3'd0},
      // threshold edge on knob 7: 410 moves, a further 409 does not
      '{REQ_SAMPLE,  3'd7, 12'd0,    1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SAMPLE,  3'd7, 12'd410,  1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SAMPLE,  3'd7, 12'd819,  1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SEND,    3'd0, 12'd0,    1'b1, 1'b1, 7'd17, 7'd12,  3'd7},
      // pickup: small move is held off, large move releases and is taken
      '{REQ_SELECT,  3'd3, 12'd2048, 1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SAMPLE,  3'd3, 12'd2400, 1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SAMPLE,  3'd3, 12'd0,    1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SAMPLE,  3'd1, 12'd1000, 1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SAMPLE,  3'd2, 12'd4095, 1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SEND,    3'd0, 12'd0,    1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      // pickup held exactly at the threshold, released one step past it
      '{REQ_SELECT,  3'd4, 12'd1000, 1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SAMPLE,  3'd4, 12'd1409, 1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SAMPLE,  3'd4, 12'd1410, 1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SAMPLE,  3'd5, 12'd2047, 1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SAMPLE,  3'd5, 12'd4095, 1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      '{REQ_SEND,    3'd0, 12'd0,    1'b0, 1'b0, 7'd0,  7'd0,   3'd0},
      // everything flushed: nothing left to send
      '{REQ_SEND,    3'd0, 12'd0,    1'b1, 1'b0, 7'd0,  7'd0,   3'd0}
   };

   // Register settings for the random phases; extremes of every register.
   typedef struct packed {
      logic [CHANNEL_W-1:0]   channel;
      logic [BANK_W-1:0]      bank;
      logic [THRESHOLD_W-1:0] threshold;
      logic                   spare;
   } reg_setting_type;

   localparam reg_setting_type PHASES [0:5] = '{
      '{4'd15, 4'd15, 12'd0,    1'b0},
      '{4'd0,  4'd0,  12'd4095, 1'b0},
      '{4'd9,  4'd6,  12'd100,  1'b0},
      '{4'd3,  4'd15, 12'd2048, 1'b1},
      '{4'd15, 4'd0,  12'd409,  1'b0},
      '{4'd7,  4'd11, 12'd1,    1'b0}
   };

   logic clock;
   logic reset;

   kcc_req_if req_bus ();
   kcc_rsp_if rsp_bus ();
   kcc_csr_if csr_bus ();

   knob_to_midi_cc_with_pickup i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Mirror of the knob bank and the registers.
   logic [KNOB_VALUE_W-1:0] knob_last    [8];
   logic                    knob_waiting [8];
   logic                    knob_pending [8];
   logic [CC_W-1:0]         knob_level   [8];
   logic [CHANNEL_W-1:0]    cfg_channel;
   logic [BANK_W-1:0]       cfg_bank;
   logic [THRESHOLD_W-1:0]  cfg_threshold;

   cc_msg_type cc_msgs_due [$];   // messages still owed by the block, oldest first
   int         mismatch_count;
   bit         req_quiet;         // back-to-back stretch on the request side
   bit         rsp_quiet;         // no-stall stretch on the response side

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Bound on the whole run, far above the slowest legal schedule.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Update the mirror for one accepted request and queue the CC messages a
   // send run must produce, lowest knob first, last flag on the final one.
   function automatic void forecast_cc_msgs(input logic [REQ_TYPE_W-1:0]   kind,
                                            input logic [KNOB_INDEX_W-1:0] knob,
                                            input logic [KNOB_VALUE_W-1:0] value);
      int unsigned step;
      bit          moved;
      logic [31:0] scaled;
      int          top;
      cc_msg_type  msg;
      case (kind)
         REQ_SAMPLE: begin
            step  = (value > knob_last[knob]) ? value - knob_last[knob]
                                              : knob_last[knob] - value;
            moved = step > cfg_threshold;
            // a move that clears the threshold also ends the pickup wait
            if (knob_waiting[knob] && moved) knob_waiting[knob] = 1'b0;
            if (!knob_waiting[knob] && moved) begin
               knob_last[knob]    = value;
               scaled             = (32'(value) * 127) / FULL_SCALE;
               knob_level[knob]   = scaled[CC_W-1:0];
               knob_pending[knob] = 1'b1;
            end
         end
         REQ_SELECT: begin
            knob_last[knob]    = value;
            knob_waiting[knob] = 1'b1;
         end
         REQ_SEND: begin
            top = -1;
            for (int k = 0; k < 8; k++) if (knob_pending[k]) top = k;
            for (int k = 0; k < 8; k++) begin
               if (knob_pending[k]) begin
                  msg.status      = STATUS_CC + {4'd0, cfg_channel};
                  msg.number      = CC_BASE + {cfg_bank, 3'b000} + CC_W'(k);
                  msg.level       = knob_level[k];
                  msg.knob        = KNOB_INDEX_W'(k);
                  msg.last        = (k == top);
                  knob_pending[k] = 1'b0;
                  cc_msgs_due.push_back(msg);
               end
            end
         end
         default: ;   // unknown request: no effect
      endcase
   endfunction

   // One request transaction, after a random gap; the mirror is updated at
   // the accepting edge. valid is left high so a zero gap gives back-to-back.
   task automatic issue_request(input logic [REQ_TYPE_W-1:0]   kind,
                                input logic [KNOB_INDEX_W-1:0] knob,
                                input logic [KNOB_VALUE_W-1:0] value);
      int gap;
      if ($urandom_range(0, 15) == 0) req_quiet = !req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.knob_index <= knob;
      req_bus.knob_value <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      forecast_cc_msgs(kind, knob, value);
   endtask

   // Register write; the caller lowers valid after its last write.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  wdata);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= wdata;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_MIDI_CHANNEL:   cfg_channel   = wdata[CHANNEL_W-1:0];
         CSR_BANK_INDEX:     cfg_bank      = wdata[BANK_W-1:0];
         CSR_MOVE_THRESHOLD: cfg_threshold = wdata[THRESHOLD_W-1:0];
         default: ;          // no register behind this index
      endcase
   endtask

   // Stop requesting, wait for every owed message, then let a sample or
   // select still in flight finish before registers change.
   task automatic drain(input int extra);
      req_bus.valid <= 1'b0;
      while (cc_msgs_due.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Response side: random stall before each transaction, then compare.
   initial begin : rsp_side
      int         stall;
      cc_msg_type want;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_quiet = !rsp_quiet;
         stall = rsp_quiet ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock);
         while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
         if (cc_msgs_due.size() == 0) begin
            $error("unexpected CC message: knob %0d value %0d",
                   rsp_bus.source_knob, rsp_bus.controller_value);
            mismatch_count++;
         end else begin
            want = cc_msgs_due.pop_front();
            if (rsp_bus.status_byte !== want.status) begin
               $error("status_byte: expected %0h, got %0h", want.status, rsp_bus.status_byte);
               mismatch_count++;
            end
            if (rsp_bus.controller_number !== want.number) begin
               $error("controller_number: expected %0d, got %0d",
                      want.number, rsp_bus.controller_number);
               mismatch_count++;
            end
            if (rsp_bus.controller_value !== want.level) begin
               $error("controller_value: expected %0d, got %0d",
                      want.level, rsp_bus.controller_value);
               mismatch_count++;
            end
            if (rsp_bus.source_knob !== want.knob) begin
               $error("source_knob: expected %0d, got %0d", want.knob, rsp_bus.source_knob);
               mismatch_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_bus.last);
               mismatch_count++;
            end
         end
      end
   end

   // Request side and run control.
   initial begin : stimulus
      int                      n_prior;
      int                      pick;
      int                      aim;
      logic [REQ_TYPE_W-1:0]   kind;
      logic [KNOB_INDEX_W-1:0] knob;
      logic [KNOB_VALUE_W-1:0] value;

      mismatch_count = 0;
      req_quiet      = 1'b0;
      rsp_quiet      = 1'b0;
      cfg_channel    = '0;
      cfg_bank       = '0;
      cfg_threshold  = THRESHOLD_RESET;
      for (int k = 0; k < 8; k++) begin
         knob_last[k]    = '0;
         knob_waiting[k] = 1'b0;
         knob_pending[k] = 1'b0;
         knob_level[k]   = '0;
      end

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= REQ_SAMPLE;
      req_bus.knob_index <= '0;
      req_bus.knob_value <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= CSR_MIDI_CHANNEL;
      csr_bus.data       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // scripted opening at reset register values
      foreach (SCRIPT[i]) begin
         n_prior = cc_msgs_due.size();
         issue_request(SCRIPT[i].kind, SCRIPT[i].knob, SCRIPT[i].value);
         if (SCRIPT[i].fixed) begin
            while (cc_msgs_due.size() > n_prior) cc_msgs_due.delete(cc_msgs_due.size() - 1);
            if (SCRIPT[i].has_msg)
               cc_msgs_due.push_back(cc_msg_type'{STATUS_CC, SCRIPT[i].number,
                                                   SCRIPT[i].level, SCRIPT[i].src, 1'b1});
         end
      end
      drain(SETTLE_CYCLES);

      foreach (PHASES[p]) begin
         // channel and bank writes carry junk in the unused upper data bits
         write_reg(CSR_MIDI_CHANNEL,   {8'($urandom), PHASES[p].channel});
         write_reg(CSR_BANK_INDEX,     {8'($urandom), PHASES[p].bank});
         write_reg(CSR_MOVE_THRESHOLD, PHASES[p].threshold);
         if (PHASES[p].spare) write_reg(CSR_SPARE, 12'($urandom));
         csr_bus.valid <= 1'b0;

         repeat (ITEMS_PER_PHASE) begin
            pick  = $urandom_range(0, 99);
            knob  = 3'($urandom);
            value = 12'($urandom);
            if (pick < 55) begin
               kind = REQ_SAMPLE;
               // bias toward the threshold edge and the ends of the range
               case ($urandom_range(0, 3))
                  1: begin
                     aim = int'(knob_last[knob]) + int'(cfg_threshold) + $urandom_range(0, 1);
                     if (aim > FULL_SCALE)
                        aim = int'(knob_last[knob]) - int'(cfg_threshold)
                              - $urandom_range(0, 1);
                     if (aim >= 0 && aim <= FULL_SCALE) value = 12'(aim);
                  end
                  2: value = $urandom_range(0, 1) ? 12'(FULL_SCALE) : 12'd0;
                  default: ;
               endcase
            end else if (pick < 65) begin
               kind = REQ_SELECT;
            end else if (pick < 93) begin
               kind = REQ_SEND;
            end else begin
               kind = REQ_UNKNOWN;
            end
            issue_request(kind, knob, value);
         end
         drain(SETTLE_CYCLES);
      end

      // one last flush so nothing is left pending, then a quiet tail
      issue_request(REQ_SEND, '0, '0);
      drain(SETTLE_CYCLES + 2);

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
